// ----- rtl/intermeeting_time_table_assert.svh -----
// Assertion macros shared by the intermeeting time table RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef INTERMEETING_TIME_TABLE_ASSERT_SVH
`define INTERMEETING_TIME_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/itt_pkg.sv -----
// Shared types and constants for the intermeeting time table.
// No dependencies.
`default_nettype none

package itt_pkg;

	localparam int CMD_W   = 2;
	localparam int PEER_W  = 6;
	localparam int TIME_W  = 32;
	localparam int OPEN_W  = 8;
	localparam int MEET_W  = 32;
	localparam int TOTAL_W = 48;
	localparam int UTIL_W  = 17;
	localparam int DEN_W   = TOTAL_W + 1;
	localparam int REM_W   = TOTAL_W + 2;
	localparam int QCNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_UP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [OPEN_W-1:0]  OPEN_MAX  = '1;
	localparam logic [MEET_W-1:0]  MEET_MAX  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [UTIL_W-1:0]  UTIL_ONE  = 17'd65536;
	localparam logic [QCNT_W-1:0]  QCNT_LAST = 5'd16;

	typedef struct packed {
		logic [OPEN_W-1:0]  open_count;
		logic [MEET_W-1:0]  meeting_count;
		logic [TOTAL_W-1:0] gap_total;
		logic [TIME_W-1:0]  last_down_time;
	} row_t;

	typedef struct packed {
		logic load_req;
		logic clr_wr;
		logic mem_rd;
		logic exec;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic div_needed;
		logic div_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/intermeeting_time_table.sv -----
// Intermeeting time table: per-peer contact statistics with a utility query
// (meetings/(meetings+gap total) in Q1.16). A request is accepted in idle and
// then passes through read (fetch the peer row), exec (update the row and write
// it back) and done (load the result register once it is free); no new
// request is taken until the block is back in idle. A query on a peer with two
// or more meetings adds a divide state between exec and done, where a restoring
// divider makes one quotient bit per cycle. A peer index outside the table
// skips exec and yields zeros. After reset a clearing pass writes zero to every
// row, one per cycle; in_stall stays high meanwhile. The result register lets
// the next request enter while a finished result still waits on out_stall.
// Depends on itt_pkg, itt_ctrl and itt_datapath.
`default_nettype none

module intermeeting_time_table import itt_pkg::*; #(
	parameter int NUM_PEERS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [PEER_W-1:0]  peer,
	input  wire logic [TIME_W-1:0]  now,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [UTIL_W-1:0]       utility,
	output logic                    contact_open
);

	// Commands from the sequencer, status back from the datapath.
	ctrl_cmd_t ctl_cmd;
	ctrl_sts_t ctl_sts;

	itt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	itt_datapath #(
		.NUM_PEERS (NUM_PEERS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (ctl_sts),
		.in_cmd       (cmd),
		.in_peer      (peer),
		.in_now       (now),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.utility      (utility),
		.contact_open (contact_open)
	);

endmodule

`default_nettype wire

// ----- rtl/itt_ctrl.sv -----
// Sequencer for the intermeeting time table: clear sweep, read, update, divide, deliver.
// Depends on itt_pkg and intermeeting_time_table_assert.svh.
`default_nettype none

`include "intermeeting_time_table_assert.svh"

module itt_ctrl import itt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire ctrl_sts_t  sts,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd          = '0;
		cmd.load_req = (state_q == S_IDLE) && in_valid;
		cmd.clr_wr   = (state_q == S_CLEAR);
		cmd.mem_rd   = (state_q == S_READ) && sts.in_range;
		cmd.exec     = (state_q == S_EXEC);
		cmd.div_step = (state_q == S_DIV);
		cmd.out_load = (state_q == S_DONE) && sts.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= sts.in_range ? S_EXEC : S_DONE;
				end
				S_EXEC: begin
					state_q <= sts.div_needed ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ITT_ASSERT_NXT(a_div_follows_exec, cmd.exec && sts.div_needed, state_q == S_DIV, "divide skipped")
	`ITT_ASSERT_IMP(a_clear_blocks_input, state_q == S_CLEAR, in_stall, "request taken during clear")

endmodule

`default_nettype wire

// ----- rtl/itt_datapath.sv -----
// Datapath of the intermeeting time table: peer table memory, update logic, divider, result register.
// Depends on itt_pkg and intermeeting_time_table_assert.svh.
`default_nettype none

`include "intermeeting_time_table_assert.svh"

module itt_datapath import itt_pkg::*; #(
	parameter int NUM_PEERS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_cmd_t          cmd,
	output ctrl_sts_t               sts,
	input  wire logic [CMD_W-1:0]   in_cmd,
	input  wire logic [PEER_W-1:0]  in_peer,
	input  wire logic [TIME_W-1:0]  in_now,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic [UTIL_W-1:0]       utility,
	output logic                    contact_open
);

	localparam int IDX_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PEERS - 1);

	row_t mem [NUM_PEERS];

	logic [CMD_W-1:0]  cmd_q;
	logic [PEER_W-1:0] peer_q;
	logic [TIME_W-1:0] now_q;
	row_t              rd_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic              res_open_q;
	logic              div_used_q;
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [UTIL_W-1:0] quo_q;
	logic [QCNT_W-1:0] qcnt_q;
	logic              out_valid_q;
	logic [UTIL_W-1:0] util_q;
	logic              open_q;

	logic [IDX_W-1:0]   addr;
	logic               in_range;
	row_t               new_row;
	logic [MEET_W-1:0]  meet_inc;
	logic [TIME_W-1:0]  gap;
	logic [TOTAL_W:0]   sum;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	row_t               wr_data;
	logic               div_needed;
	logic               rem_ge;
	logic [REM_W-1:0]   rem_sub;

	assign addr     = IDX_W'(peer_q);
	assign in_range = (32'(peer_q) < 32'(NUM_PEERS));

	// Row update for contact up and down.
	always_comb begin
		new_row  = rd_q;
		meet_inc = (rd_q.meeting_count == MEET_MAX) ? MEET_MAX : rd_q.meeting_count + 1'b1;
		gap      = (now_q >= rd_q.last_down_time) ? now_q - rd_q.last_down_time : '0;
		sum      = {1'b0, rd_q.gap_total} + (TOTAL_W + 1)'(gap);
		case (cmd_q)
			CMD_UP: begin
				if (rd_q.open_count != '0) begin
					if (rd_q.open_count != OPEN_MAX)
						new_row.open_count = rd_q.open_count + 1'b1;
				end else begin
					new_row.open_count    = OPEN_W'(1);
					new_row.meeting_count = meet_inc;
					if (meet_inc > MEET_W'(1))
						new_row.gap_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
				end
			end
			CMD_DOWN: begin
				if (rd_q.open_count != '0) begin
					new_row.open_count = rd_q.open_count - 1'b1;
					if (rd_q.open_count == OPEN_W'(1))
						new_row.last_down_time = now_q;
				end
			end
			default: begin
				new_row = rd_q;
			end
		endcase
	end

	assign div_needed = (cmd_q == CMD_QUERY) && (rd_q.meeting_count > MEET_W'(1));
	assign mem_we     = cmd.clr_wr || (cmd.exec && in_range);
	assign wr_addr    = cmd.clr_wr ? clr_cnt_q : addr;
	assign wr_data    = cmd.clr_wr ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (cmd.mem_rd) rd_q <= mem[addr];
	end

	// Restoring division, one quotient bit per step.
	assign rem_ge  = (rem_q >= REM_W'(den_q));
	assign rem_sub = rem_ge ? rem_q - REM_W'(den_q) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_q      <= in_cmd;
			peer_q     <= in_peer;
			now_q      <= in_now;
			res_open_q <= 1'b0;
			div_used_q <= 1'b0;
		end
		if (cmd.exec) begin
			res_open_q <= (new_row.open_count != '0);
			div_used_q <= div_needed;
			rem_q      <= REM_W'(rd_q.meeting_count);
			den_q      <= DEN_W'(rd_q.meeting_count) + DEN_W'(rd_q.gap_total);
			quo_q      <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[UTIL_W-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			util_q <= div_used_q ? quo_q : '0;
			open_q <= res_open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			qcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.exec) qcnt_q <= '0;
			else if (cmd.div_step) qcnt_q <= qcnt_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign sts.clr_last   = (clr_cnt_q == IDX_LAST);
	assign sts.in_range   = in_range;
	assign sts.div_needed = div_needed;
	assign sts.div_last   = (qcnt_q == QCNT_LAST);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign utility      = util_q;
	assign contact_open = open_q;

	`ITT_ASSERT_IMP(a_util_bound, out_valid_q, util_q <= UTIL_ONE, "utility above one")
	`ITT_ASSERT_IMP(a_write_in_range, cmd.exec && mem_we, in_range, "write to row outside table")

endmodule

`default_nettype wire

// ----- tb/tb_intermeeting_time_table.sv -----
// Self-checking testbench for the intermeeting time table: directed and random
// contact-up, contact-down and query requests, checked against a row-state predictor.
// Depends on itt_pkg and the intermeeting_time_table RTL.
`default_nettype none

module tb_intermeeting_time_table;
	import itt_pkg::*;

	localparam int NPEERS = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [UTIL_W-1:0] utility;
		logic              contact_open;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd = CMD_UP;
	logic [PEER_W-1:0] peer = '0;
	logic [TIME_W-1:0] now = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [UTIL_W-1:0] utility;
	logic              contact_open;

	// Predictor copy of the per-peer rows
	logic [OPEN_W-1:0]  opens [NPEERS];
	logic [MEET_W-1:0]  meets [NPEERS];
	logic [TOTAL_W-1:0] gaps [NPEERS];
	logic [TIME_W-1:0]  downs [NPEERS];

	outcome_t    pending_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          requests_sent = 0;
	bit          idle_enable = 1'b0;
	int          hold_cycles = 0;
	logic [TIME_W-1:0] clock_now = '0;

	intermeeting_time_table #(.NUM_PEERS(NPEERS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .peer(peer), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.utility(utility), .contact_open(contact_open)
	);

	always #6 clk = ~clk;

	// Apply one request to the predicted rows and compute its result
	function automatic outcome_t apply_request(logic [CMD_W-1:0] c, logic [PEER_W-1:0] p,
			logic [TIME_W-1:0] t);
		outcome_t    r;
		logic [63:0] gap;
		logic [63:0] num;
		logic [63:0] den;
		r.utility = '0;
		if (c == CMD_UP) begin
			if (opens[p] != 0) begin
				if (opens[p] != OPEN_MAX)
					opens[p] = opens[p] + 1'b1;
			end else begin
				opens[p] = 1;
				if (meets[p] != MEET_MAX)
					meets[p] = meets[p] + 1'b1;
				if (meets[p] > 1) begin
					gap = (t >= downs[p]) ? 64'(t - downs[p]) : 64'd0;
					if (gap > 64'(TOTAL_MAX) - 64'(gaps[p]))
						gaps[p] = TOTAL_MAX;
					else
						gaps[p] = gaps[p] + gap[TOTAL_W-1:0];
				end
			end
		end else if (c == CMD_DOWN) begin
			if (opens[p] != 0) begin
				opens[p] = opens[p] - 1'b1;
				if (opens[p] == 0)
					downs[p] = t;
			end
		end else if (c == CMD_QUERY) begin
			if (meets[p] > 1) begin
				num = 64'(meets[p]) << 16;
				den = 64'(meets[p]) + 64'(gaps[p]);
				r.utility = UTIL_W'(num / den);
			end
		end
		r.contact_open = (opens[p] != 0);
		return r;
	endfunction

	// Random sender gap when idling is on: it goes on while a draw below 13 of 100 comes up; drop valid meanwhile
	task automatic sender_gap();
		while (idle_enable && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Send one request, hold it until accepted, record the expected result
	task automatic send_request(logic [CMD_W-1:0] c, logic [PEER_W-1:0] p,
			logic [TIME_W-1:0] t);
		sender_gap();
		cmd <= c;
		peer <= p;
		now <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(apply_request(c, p, t));
		requests_sent++;
	endtask

	// Advance time and send; time stays nondecreasing in normal traffic
	task automatic send_timed(logic [CMD_W-1:0] c, logic [PEER_W-1:0] p, int step);
		clock_now = clock_now + TIME_W'(step);
		send_request(c, p, clock_now);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or a long counted hold-off when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_enable && ($urandom_range(99) < 13);
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: utility=%0d open=%0b", utility, contact_open);
			end else begin
				e = pending_results.pop_front();
				if (e.utility !== utility || e.contact_open !== contact_open) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp utility=%0d open=%0b, got utility=%0d open=%0b",
							e.utility, e.contact_open, utility, contact_open);
				end
			end
		end
	end

	// Directed: field extremes, each command, overlap, saturation of open count
	task automatic test_directed();
		send_request(CMD_QUERY, 6'd0, 32'd0);
		send_request(CMD_DOWN, 6'd0, 32'd5);             // down with nothing open
		send_request(CMD_UP, 6'd0, 32'd10);              // first meeting, no gap
		send_request(CMD_UP, 6'd0, 32'd11);              // overlapping up
		send_request(CMD_QUERY, 6'd0, 32'd12);           // one meeting gives zero
		send_request(CMD_DOWN, 6'd0, 32'd20);
		send_request(CMD_DOWN, 6'd0, 32'd30);            // last close records time
		send_request(CMD_UP, 6'd0, 32'd40);              // gap of 10
		send_request(CMD_QUERY, 6'd0, 32'd41);
		send_request(CMD_DOWN, 6'd63, 32'hFFFF_FFFF);
		send_request(CMD_UP, 6'd63, 32'hFFFF_FFFF);
		send_request(CMD_DOWN, 6'd63, 32'hFFFF_FFFF);
		send_request(CMD_UP, 6'd63, 32'd0);              // negative gap counts as zero
		send_request(CMD_QUERY, 6'd63, 32'd0);           // utility exactly one
		send_request(CMD_UNUSED, 6'd63, 32'hAAAA_5555);  // unused command
		send_request(CMD_UNUSED, 6'd1, 32'h5555_AAAA);
		for (int i = 0; i < 257; i++)                    // drive open count to its limit
			send_request(CMD_UP, 6'd42, 32'd100);
		send_request(CMD_DOWN, 6'd42, 32'd101);
		send_request(CMD_QUERY, 6'd42, 32'd102);
		wait_drained();
	endtask

	// Large gaps build up the gap total, though far short of its saturation value
	task automatic test_total_saturation();
		for (int i = 0; i < 40; i++) begin
			send_request(CMD_DOWN, 6'd7, 32'd0);
			send_request(CMD_UP, 6'd7, 32'hFFFF_FFFF);
			send_request(CMD_DOWN, 6'd7, 32'd0);
			send_request(CMD_UP, 6'd7, 32'hFFFF_FFFF);
		end
		send_request(CMD_QUERY, 6'd7, 32'd0);
		wait_drained();
	endtask

	// Random traffic: mostly well-formed up/down pairs on a few peers, plus noise
	task automatic test_random(int count);
		logic [PEER_W-1:0] p;
		int sel;
		for (int i = 0; i < count; i++) begin
			p = ($urandom_range(3) == 0) ? PEER_W'($urandom) : PEER_W'($urandom_range(7));
			sel = $urandom_range(99);
			if (sel < 35)
				send_timed(CMD_UP, p, $urandom_range(3) == 0 ? $urandom_range(1 << 20) :
					$urandom_range(50));
			else if (sel < 65)
				send_timed(CMD_DOWN, p, $urandom_range(50));
			else if (sel < 92)
				send_timed(CMD_QUERY, p, $urandom_range(5));
			else if (sel < 96)
				send_request(CMD_UP, p, $urandom);        // out-of-order time
			else
				send_request(CMD_UNUSED, p, $urandom);
		end
	endtask

	// Block output for a long stretch while requests keep coming, then a full pause
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 30; i++)
			send_timed(CMD_QUERY, PEER_W'($urandom_range(7)), 1);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < NPEERS; i++) begin
			opens[i] = '0;
			meets[i] = '0;
			gaps[i] = '0;
			downs[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_total_saturation();
		test_random(250);                                // no idling stretch
		idle_enable = 1'b1;
		test_backpressure();
		test_random(730);
		wait_drained();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests and %0d results: overlap, saturation, negative gaps,",
			requests_sent, results_seen);
		$display("out-of-range commands, random idling and a long output hold-off.");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Timeout well beyond the slowest correct run
	initial begin
		#(12 * 400000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
